// ----- src/xsp_pkg.sv -----
// Shared types, codes and helper functions of the cross-reference subsection parser.
// No dependencies; imported by every module under src.
package xsp_pkg;

	localparam int OBJ_W       = 24;
	localparam int OFF_W       = 34;
	localparam int GEN_W       = 17;
	localparam int ENTRY_BYTES = 20;
	localparam int GEN_BYTE    = 11;
	localparam int POS_W       = $clog2(ENTRY_BYTES + 1);

	localparam logic [OBJ_W-1:0] OBJ_MAX = {OBJ_W{1'b1}};
	localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};
	localparam logic [GEN_W-1:0] GEN_MAX = {GEN_W{1'b1}};

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_T    = 8'h74;
	localparam logic [7:0] CHAR_SP   = 8'h20;
	localparam logic [7:0] CHAR_TAB  = 8'h09;
	localparam logic [7:0] CHAR_CR   = 8'h0d;

	typedef enum logic {
		OP_DATA    = 1'b0,
		OP_RESTART = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_ENTRY     = 2'd0,
		KIND_TRAILER   = 2'd1,
		KIND_BAD_START = 2'd2,
		KIND_RANGE     = 2'd3
	} kind_t;

	typedef enum logic [5:0] {
		PH_SKIP  = 6'b000001,
		PH_START = 6'b000010,
		PH_COUNT = 6'b000100,
		PH_SPACE = 6'b001000,
		PH_ENTRY = 6'b010000,
		PH_HALT  = 6'b100000
	} phase_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data_byte;
	} xsp_req_t;

	typedef struct packed {
		kind_t            kind;
		logic [OBJ_W-1:0] object_number;
		logic [OFF_W-1:0] byte_offset;
		logic [GEN_W-1:0] generation;
	} xsp_res_t;

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[CHAR_ZERO:CHAR_NINE]};
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b inside {CHAR_SP, [CHAR_TAB:CHAR_CR]};
	endfunction

	// v * 10 + digit, clamped at the all-ones value of the field
	function automatic logic [OBJ_W-1:0] acc_obj(input logic [OBJ_W-1:0] v,
		input logic [7:0] b);
		logic [OBJ_W+3:0] n;
		n = ({4'b0000, v} << 3) + ({4'b0000, v} << 1) + {{OBJ_W{1'b0}}, b[3:0]};
		return (n > {4'b0000, OBJ_MAX}) ? OBJ_MAX : n[OBJ_W-1:0];
	endfunction

	function automatic logic [OFF_W-1:0] acc_off(input logic [OFF_W-1:0] v,
		input logic [7:0] b);
		logic [OFF_W+3:0] n;
		n = ({4'b0000, v} << 3) + ({4'b0000, v} << 1) + {{OFF_W{1'b0}}, b[3:0]};
		return (n > {4'b0000, OFF_MAX}) ? OFF_MAX : n[OFF_W-1:0];
	endfunction

	function automatic logic [GEN_W-1:0] acc_gen(input logic [GEN_W-1:0] v,
		input logic [7:0] b);
		logic [GEN_W+3:0] n;
		n = ({4'b0000, v} << 3) + ({4'b0000, v} << 1) + {{GEN_W{1'b0}}, b[3:0]};
		return (n > {4'b0000, GEN_MAX}) ? GEN_MAX : n[GEN_W-1:0];
	endfunction

endpackage

// ----- src/xsp_in_stage.sv -----
// Input register stage of the subsection parser: holds one request.
// Depends on xsp_pkg.
module xsp_in_stage
	import xsp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  xsp_req_t in_data,
	input  logic     advance,
	output logic     req_valid,
	output xsp_req_t req
);

	logic     valid_s1;
	xsp_req_t req_s1;

	// hold the request while the result side cannot take it
	assign in_stall  = valid_s1 & ~advance;
	assign req_valid = valid_s1;
	assign req       = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			req_s1 <= in_data;
		end
	end

endmodule

// ----- src/xsp_core.sv -----
// Parsing state and per-byte update logic of the subsection parser, with the limit register.
// Depends on xsp_pkg.
module xsp_core
	import xsp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [OBJ_W-1:0] cfg_data,
	input  logic             fire,
	input  xsp_req_t         req,
	output logic             res_valid,
	output xsp_res_t         res
);

	logic [OBJ_W-1:0] limit_q;
	phase_t           phase_q, phase_d;
	logic [OBJ_W-1:0] first_q, first_d;
	logic [OBJ_W-1:0] left_q, left_d;
	logic [OBJ_W-1:0] next_obj_q, next_obj_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [OFF_W-1:0] off_q, off_d;
	logic [GEN_W-1:0] gen_q, gen_d;
	logic [1:0]       flags_q, flags_d;

	logic [7:0]       b;
	logic             b_digit;
	logic             fresh;
	logic [POS_W-1:0] e_pos;
	logic [OFF_W-1:0] e_off;
	logic [GEN_W-1:0] e_gen;
	logic [1:0]       e_flags;
	logic             e_done;
	logic [OBJ_W-1:0] left_dec;

	assign b       = req.data_byte;
	assign b_digit = is_digit(b);
	// the first byte of a subsection's first entry arrives in the whitespace phase
	assign fresh   = (phase_q == PH_SPACE);

	// entry byte: offset digits from byte 0, generation digits from byte 11
	always_comb begin
		e_pos   = fresh ? '0 : pos_q;
		e_off   = fresh ? '0 : off_q;
		e_gen   = fresh ? '0 : gen_q;
		e_flags = fresh ? 2'b11 : flags_q;
		if (e_flags[0]) begin
			if (b_digit) e_off = acc_off(e_off, b);
			else e_flags[0] = 1'b0;
		end
		if ((e_pos >= POS_W'(GEN_BYTE)) && e_flags[1]) begin
			if (b_digit) e_gen = acc_gen(e_gen, b);
			else e_flags[1] = 1'b0;
		end
		e_pos  = e_pos + POS_W'(1);
		e_done = (e_pos == POS_W'(ENTRY_BYTES));
	end

	assign left_dec = (left_q != '0) ? left_q - OBJ_W'(1) : left_q;

	always_comb begin
		phase_d    = phase_q;
		first_d    = first_q;
		left_d     = left_q;
		next_obj_d = next_obj_q;
		pos_d      = pos_q;
		off_d      = off_q;
		gen_d      = gen_q;
		flags_d    = flags_q;
		res_valid  = 1'b0;
		res        = '0;

		if (req.op == OP_RESTART) begin
			phase_d    = PH_SKIP;
			first_d    = '0;
			left_d     = '0;
			next_obj_d = '0;
			pos_d      = '0;
			off_d      = '0;
			gen_d      = '0;
			flags_d    = 2'b11;
		end else begin
			case (phase_q)
				PH_SKIP: begin
					if (b == CHAR_T) begin
						phase_d   = PH_HALT;
						res_valid = 1'b1;
						res.kind  = KIND_TRAILER;
					end else if (b_digit) begin
						first_d = {{(OBJ_W-4){1'b0}}, b[3:0]};
						phase_d = PH_START;
					end
				end
				PH_START: begin
					if (b_digit) begin
						first_d = acc_obj(first_q, b);
					end else begin
						next_obj_d = first_q;
						left_d     = '0;
						phase_d    = PH_COUNT;
					end
				end
				PH_COUNT: begin
					if (b_digit) begin
						left_d = acc_obj(left_q, b);
					end else if (is_space(b)) begin
						phase_d = PH_SPACE;
					end else begin
						phase_d   = PH_HALT;
						res_valid = 1'b1;
						res.kind  = KIND_BAD_START;
					end
				end
				PH_SPACE, PH_ENTRY: begin
					if (fresh && is_space(b)) begin
						phase_d = PH_SPACE;
					end else if (fresh && (b != CHAR_ZERO)) begin
						phase_d   = PH_HALT;
						res_valid = 1'b1;
						res.kind  = KIND_BAD_START;
					end else if (fresh && (left_q == '0)) begin
						// empty subsection: the zero opens the next start number
						first_d = '0;
						phase_d = PH_START;
					end else begin
						phase_d = PH_ENTRY;
						pos_d   = e_pos;
						off_d   = e_off;
						gen_d   = e_gen;
						flags_d = e_flags;
						if (e_done) begin
							res_valid         = 1'b1;
							res.object_number = next_obj_q;
							res.byte_offset   = e_off;
							res.generation    = e_gen;
							pos_d             = '0;
							if (next_obj_q >= limit_q) begin
								res.kind = KIND_RANGE;
								phase_d  = PH_HALT;
							end else begin
								res.kind = KIND_ENTRY;
								if (next_obj_q != OBJ_MAX) next_obj_d = next_obj_q + OBJ_W'(1);
								left_d = left_dec;
								if (left_dec == '0) begin
									phase_d = PH_SKIP;
								end else begin
									off_d   = '0;
									gen_d   = '0;
									flags_d = 2'b11;
								end
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= OBJ_MAX;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SKIP;
			first_q    <= '0;
			left_q     <= '0;
			next_obj_q <= '0;
			pos_q      <= '0;
			off_q      <= '0;
			gen_q      <= '0;
			flags_q    <= 2'b11;
		end else if (fire) begin
			phase_q    <= phase_d;
			first_q    <= first_d;
			left_q     <= left_d;
			next_obj_q <= next_obj_d;
			pos_q      <= pos_d;
			off_q      <= off_d;
			gen_q      <= gen_d;
			flags_q    <= flags_d;
		end
	end

`ifndef SYNTHESIS
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (phase_q == PH_HALT)) |-> !res_valid)
		else $error("result produced while halted");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (req.op == OP_RESTART)) |=> ((phase_q == PH_SKIP) && (pos_q == '0)))
		else $error("restart did not clear the parser");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < POS_W'(ENTRY_BYTES))
		else $error("entry position past entry end");

	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_valid && (res.kind != KIND_ENTRY)) |=> (phase_q == PH_HALT))
		else $error("parser did not halt after trailer or error");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && ((res.kind == KIND_TRAILER) || (res.kind == KIND_BAD_START)))
		|-> ((res.object_number == '0) && (res.byte_offset == '0)
			&& (res.generation == '0)))
		else $error("non-entry result carries field data");
`endif

endmodule

// ----- src/xsp_out_stage.sv -----
// Result register of the subsection parser, presented on the output channel.
// Depends on xsp_pkg.
module xsp_out_stage
	import xsp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  logic     res_valid,
	input  xsp_res_t res,
	output logic     advance,
	output logic     out_valid,
	input  logic     out_stall,
	output xsp_res_t out_data
);

	logic     valid_q;
	xsp_res_t data_q;

	// register is free when empty or being taken this cycle
	assign advance   = ~valid_q | ~out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= fire & res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			data_q <= res;
		end
	end

endmodule

// ----- src/xref_subsection_parser.sv -----
// Top level of the cross-reference subsection parser.
// Depends on xsp_pkg, xsp_in_stage, xsp_core and xsp_out_stage.
//
// Feed the bytes that follow the xref keyword, one request per byte; a request
// with op set to restart clears the parser for a new section. The parser skips
// to a digit or 't', reads the start object number and the entry count, then
// for each 20-byte entry reports object number, offset and generation. A 't'
// reports the trailer; a bad entry start or an object number at or above
// object_limit reports an error. After a trailer or an error, drop all data
// bytes silently until a restart. One byte is taken every clock cycle while
// the output is not stalled; a byte passes the input register, its report the
// result register, and the cycle rate is bounded by the multiply-by-ten-and-add
// of the 34-bit offset accumulator plus the state update. No clearing pass
// follows reset: the parser is ready at once.
// object_limit is written through the cfg channel, which is always ready;
// write it only while the parser is idle.
module xref_subsection_parser
	import xsp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  xsp_req_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output xsp_res_t         out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [OBJ_W-1:0] cfg_data
);

	logic     advance;
	logic     req_valid;
	xsp_req_t req;
	logic     fire;
	logic     res_valid;
	xsp_res_t res;

	assign cfg_ready = 1'b1;

	// advance a held request into the state update when the result register frees up
	assign fire = req_valid & advance;

	xsp_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.advance   (advance),
		.req_valid (req_valid),
		.req       (req)
	);

	xsp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.req       (req),
		.res_valid (res_valid),
		.res       (res)
	);

	xsp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for xref_subsection_parser: byte requests in, reports out.
// Depends on xsp_pkg and the parser sources under src; needs nothing else.
module tb;
	import xsp_pkg::*;

	// Block ports. Every input starts at a known value before reset is released.
	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	xsp_req_t         in_data   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	xsp_res_t         out_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [OBJ_W-1:0] cfg_data  = '0;

	// Scanner mirror: the bench's own copy of the parser state and of object_limit.
	phase_t           sc_phase;
	logic [OBJ_W-1:0] sc_first;
	logic [OBJ_W-1:0] sc_left;
	logic [OBJ_W-1:0] sc_next;
	logic [OBJ_W-1:0] sc_limit;
	int               sc_pos;
	logic [OFF_W-1:0] sc_off;
	logic [GEN_W-1:0] sc_gen;
	logic [1:0]       sc_runs;     // bit 0: offset digits running, bit 1: generation digits

	// Byte requests still to send, reports owed by the parser, limits still to write.
	xsp_req_t         bytes_waiting[$];
	xsp_res_t         reports_due[$];
	logic [OBJ_W-1:0] limits_waiting[$];

	xsp_res_t         fresh_report;
	xsp_res_t         due;
	bit               fresh_hit;
	bit               quiet;
	int               idle_odds;
	int               gap_left;
	int               stall_left;
	int               bytes_taken;
	int               reports_seen;
	int               limit_writes;
	int               fail_count;
	int               mismatch_shown;
	int               kind_seen[4];
	int               gen_bytes;
	int               gen_entries;

	xref_subsection_parser DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run of this stimulus.
	initial begin
		#2000000;
		$display("tb failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Scanner mirror
	// ------------------------------------------------------------------

	function automatic bit dec_digit(input logic [7:0] b);
		return b inside {[CHAR_ZERO:CHAR_NINE]};
	endfunction

	function automatic bit white_byte(input logic [7:0] b);
		return b inside {CHAR_SP, [CHAR_TAB:CHAR_CR]};
	endfunction

	// Shift in one decimal digit, pinned at the field's all-ones value.
	function automatic longint unsigned dec_push(input longint unsigned v,
		input logic [7:0] b, input longint unsigned cap);
		longint unsigned n;
		n = v * 10 + b[3:0];
		return (n > cap) ? cap : n;
	endfunction

	function automatic void clear_scan();
		sc_phase = PH_SKIP;
		sc_first = '0;
		sc_left  = '0;
		sc_next  = '0;
		sc_pos   = 0;
		sc_off   = '0;
		sc_gen   = '0;
		sc_runs  = 2'b11;
	endfunction

	function automatic void open_entry();
		sc_pos   = 0;
		sc_off   = '0;
		sc_gen   = '0;
		sc_runs  = 2'b11;
		sc_phase = PH_ENTRY;
	endfunction

	// One byte of a 20-byte entry; a report falls out on the last byte.
	function automatic bit entry_step(input logic [7:0] b, output xsp_res_t res);
		res = '0;
		if (sc_runs[0]) begin
			if (dec_digit(b)) sc_off = OFF_W'(dec_push(sc_off, b, OFF_MAX));
			else sc_runs[0] = 1'b0;
		end
		if (sc_pos >= GEN_BYTE && sc_runs[1]) begin
			if (dec_digit(b)) sc_gen = GEN_W'(dec_push(sc_gen, b, GEN_MAX));
			else sc_runs[1] = 1'b0;
		end
		sc_pos++;
		if (sc_pos < ENTRY_BYTES) return 1'b0;
		res.object_number = sc_next;
		res.byte_offset   = sc_off;
		res.generation    = sc_gen;
		if (sc_next >= sc_limit) begin
			// object past the table: report it and halt
			res.kind = KIND_RANGE;
			sc_phase = PH_HALT;
			sc_pos   = 0;
			return 1'b1;
		end
		res.kind = KIND_ENTRY;
		if (sc_next != OBJ_MAX) sc_next++;
		if (sc_left != '0) sc_left--;
		if (sc_left == '0) begin
			sc_phase = PH_SKIP;
			sc_pos   = 0;
		end else begin
			open_entry();
		end
		return 1'b1;
	endfunction

	// Advance the mirror by one accepted request; return 1 with the report it owes.
	function automatic bit scan_byte(input xsp_req_t req, output xsp_res_t res);
		logic [7:0] b;
		bit         hit;
		b   = req.data_byte;
		res = '0;
		hit = 1'b0;
		if (req.op == OP_RESTART) begin
			clear_scan();
			return 1'b0;
		end
		case (sc_phase)
			PH_SKIP: begin
				if (b == CHAR_T) begin
					sc_phase = PH_HALT;
					res.kind = KIND_TRAILER;
					hit      = 1'b1;
				end else if (dec_digit(b)) begin
					sc_first = {{(OBJ_W-4){1'b0}}, b[3:0]};
					sc_phase = PH_START;
				end
			end
			PH_START: begin
				if (dec_digit(b)) begin
					sc_first = OBJ_W'(dec_push(sc_first, b, OBJ_MAX));
				end else begin
					sc_next  = sc_first;
					sc_left  = '0;
					sc_phase = PH_COUNT;
				end
			end
			PH_COUNT: begin
				if (dec_digit(b)) begin
					sc_left = OBJ_W'(dec_push(sc_left, b, OBJ_MAX));
				end else if (white_byte(b)) begin
					sc_phase = PH_SPACE;
				end else begin
					sc_phase = PH_HALT;
					res.kind = KIND_BAD_START;
					hit      = 1'b1;
				end
			end
			PH_SPACE: begin
				if (white_byte(b)) begin
					// keep skipping whitespace
				end else if (b != CHAR_ZERO) begin
					sc_phase = PH_HALT;
					res.kind = KIND_BAD_START;
					hit      = 1'b1;
				end else if (sc_left == '0) begin
					// empty subsection: this '0' opens the next header
					sc_first = '0;
					sc_phase = PH_START;
				end else begin
					open_entry();
					hit = entry_step(b, res);
				end
			end
			PH_ENTRY: hit = entry_step(b, res);
			default: ;
		endcase
		return hit;
	endfunction

	// ------------------------------------------------------------------
	// Request driver: feed bytes_waiting, predict at acceptance
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			gap_left = 0;
		end else begin
			// A request moves on this edge: work out what it owes.
			if (in_valid && !in_stall) begin
				bytes_taken++;
				fresh_hit = scan_byte(in_data, fresh_report);
				if (fresh_hit) reports_due.push_back(fresh_report);
			end
			// Decide the next cycle with one assignment to in_valid.
			if (in_valid && in_stall) begin
				// hold the stalled request as it is
			end else if (!quiet && gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (!quiet && $urandom_range(0, idle_odds) == 0) begin
				// open an idle burst
				in_valid <= 1'b0;
				gap_left = $urandom_range(0, 4);
			end else if (bytes_waiting.size() > 0) begin
				in_valid <= 1'b1;
				in_data  <= bytes_waiting.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Report monitor: random stall bursts, compare with the oldest report due
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				reports_seen++;
				if (reports_due.size() == 0) begin
					fail_count++;
					if (mismatch_shown < 10) begin
						mismatch_shown++;
						$display("report %0d arrived with none due: kind %0d obj %0d off %0d gen %0d",
							reports_seen, out_data.kind, out_data.object_number,
							out_data.byte_offset, out_data.generation);
					end
				end else begin
					due = reports_due.pop_front();
					kind_seen[due.kind]++;
					if (out_data.kind !== due.kind ||
						out_data.object_number !== due.object_number ||
						out_data.byte_offset !== due.byte_offset ||
						out_data.generation !== due.generation) begin
						fail_count++;
						if (mismatch_shown < 10) begin
							mismatch_shown++;
							$display("report %0d differs: expected kind %0d obj %0d off %0d gen %0d",
								reports_seen, due.kind, due.object_number, due.byte_offset,
								due.generation);
							$display("  got kind %0d obj %0d off %0d gen %0d",
								out_data.kind, out_data.object_number, out_data.byte_offset,
								out_data.generation);
						end
					end
				end
			end
			if (quiet) begin
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if ($urandom_range(0, idle_odds) == 0) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(0, 4);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Limit writer: one write per queued value, mirror updated on acceptance
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_data  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				sc_limit = cfg_data;
				limit_writes++;
			end
			if (cfg_valid && !cfg_ready) begin
				// hold the write until it is taken
			end else if (limits_waiting.size() > 0) begin
				cfg_valid <= 1'b1;
				cfg_data  <= limits_waiting.pop_front();
			end else begin
				cfg_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------

	function automatic void push_req(input op_t op, input logic [7:0] b);
		xsp_req_t r;
		r.op        = op;
		r.data_byte = b;
		bytes_waiting.push_back(r);
		gen_bytes++;
	endfunction

	function automatic logic [7:0] rand_digit();
		logic [7:0] d;
		d = 8'($urandom_range(0, 9));
		return CHAR_ZERO + d;
	endfunction

	function automatic logic [7:0] rand_space();
		logic [7:0] pick;
		pick = 8'($urandom_range(0, 9));
		return (pick < 5) ? CHAR_SP : CHAR_TAB + (pick - 8'd5);
	endfunction

	// Filler between headers: mostly bytes the skip state passes over.
	function automatic logic [7:0] skip_noise();
		logic [7:0] b;
		if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
		do b = 8'($urandom_range(0, 255)); while (dec_digit(b) || b == CHAR_T);
		return b;
	endfunction

	// A byte that is not whitespace and cannot stand where an entry start is wanted.
	function automatic logic [7:0] bad_lead();
		logic [7:0] b;
		if ($urandom_range(0, 2) == 0) begin
			b = 8'($urandom_range(1, 9));
			return CHAR_ZERO + b;
		end
		do b = 8'($urandom_range(0, 255)); while (dec_digit(b) || white_byte(b));
		return b;
	endfunction

	function automatic void push_number(input longint unsigned v);
		logic [7:0] text[$];
		logic [7:0] d;
		do begin
			d = 8'(v % 10);
			text.push_front(CHAR_ZERO + d);
			v = v / 10;
		end while (v != 0);
		foreach (text[i]) push_req(OP_DATA, text[i]);
	endfunction

	// One entry laid out as "oooooooooo ggggg n\r\n", with odd run lengths and
	// stray bytes now and then; only the first `keep` bytes are queued.
	function automatic void queue_entry(input bit first, input int keep);
		logic [7:0] e[ENTRY_BYTES];
		int         off_len;
		int         gen_len;
		for (int i = 0; i < ENTRY_BYTES; i++) e[i] = rand_digit();
		e[10] = CHAR_SP;
		e[16] = CHAR_SP;
		e[17] = $urandom_range(0, 1) ? 8'h6e : 8'h66;
		e[18] = CHAR_CR;
		e[19] = 8'h0a;
		off_len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, ENTRY_BYTES) : 10;
		gen_len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8) : 5;
		for (int i = GEN_BYTE; i < ENTRY_BYTES; i++) begin
			if (i < GEN_BYTE + gen_len) e[i] = rand_digit();
			else if (i == GEN_BYTE + gen_len) e[i] = CHAR_SP;
		end
		for (int i = 0; i < off_len; i++) e[i] = rand_digit();
		if (off_len < ENTRY_BYTES) e[off_len] = CHAR_SP;
		for (int i = 1; i < ENTRY_BYTES; i++)
			if ($urandom_range(0, 31) == 0) e[i] = 8'($urandom_range(0, 255));
		if (first) e[0] = CHAR_ZERO;
		else if ($urandom_range(0, 7) == 0) e[0] = 8'($urandom_range(0, 255));
		for (int i = 0; i < keep; i++) push_req(OP_DATA, e[i]);
	endfunction

	// Header "start count" plus its entries; now and then broken on purpose.
	function automatic void queue_subsection();
		int pick;
		int count;
		bit huge_count;
		pick = $urandom_range(0, 9);
		if (pick == 0) repeat ($urandom_range(9, 12)) push_req(OP_DATA, rand_digit());
		else if (pick == 1) push_number($urandom_range(0, OBJ_MAX));
		else push_number($urandom_range(0, 40));
		push_req(OP_DATA, ($urandom_range(0, 7) == 0) ? skip_noise() : CHAR_SP);

		pick       = $urandom_range(0, 11);
		huge_count = 1'b0;
		if (pick == 0) begin
			count = 0;
		end else if (pick == 1) begin
			count      = 3;
			huge_count = 1'b1;
		end else begin
			count = $urandom_range(1, 4);
		end
		if (huge_count) push_number(64'd99999999999);
		else push_number(count);

		if ($urandom_range(0, 15) == 0) begin
			// count terminator that is not whitespace
			push_req(OP_DATA, bad_lead());
			return;
		end
		repeat ($urandom_range(1, 3)) push_req(OP_DATA, rand_space());
		if (count == 0) begin
			// this '0' becomes the first digit of the following header
			push_req(OP_DATA, CHAR_ZERO);
			return;
		end
		if ($urandom_range(0, 15) == 0) begin
			push_req(OP_DATA, bad_lead());
			return;
		end
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 39) == 0) begin
				// cut the entry short and restart mid-way
				queue_entry(i == 0, $urandom_range(1, ENTRY_BYTES - 1));
				push_req(OP_RESTART, 8'($urandom_range(0, 255)));
				return;
			end
			queue_entry(i == 0, ENTRY_BYTES);
			gen_entries++;
		end
		// a saturated count never runs out: drop the rest with a restart
		if (huge_count) push_req(OP_RESTART, 8'($urandom_range(0, 255)));
	endfunction

	function automatic void queue_section();
		if ($urandom_range(0, 3) != 0) push_req(OP_RESTART, 8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 3)) push_req(OP_DATA, skip_noise());
		repeat ($urandom_range(1, 3)) queue_subsection();
		case ($urandom_range(0, 3))
			0: push_req(OP_DATA, CHAR_T);
			1: begin
				push_req(OP_DATA, CHAR_T);
				push_req(OP_DATA, skip_noise());
			end
			default: ;
		endcase
	endfunction

	// Queue sections until this phase has enough bytes and complete entries.
	function automatic void random_phase(input int min_bytes);
		int bytes_at;
		int entries_at;
		bytes_at   = gen_bytes;
		entries_at = gen_entries;
		push_req(OP_RESTART, 8'($urandom_range(0, 255)));
		while (gen_bytes - bytes_at < min_bytes || gen_entries - entries_at < 3)
			queue_section();
	endfunction

	// Wait for every request to go and every report to arrive, then let the
	// two-stage pipe empty of requests that owe nothing.
	task automatic settle();
		while (bytes_waiting.size() != 0 || in_valid || reports_due.size() != 0)
			@(negedge clk);
		repeat (5) @(negedge clk);
	endtask

	// Write object_limit only once the parser has gone quiet.
	task automatic write_limit(input logic [OBJ_W-1:0] v);
		settle();
		limits_waiting.push_back(v);
		while (limits_waiting.size() != 0 || cfg_valid) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Run sequence
	// ------------------------------------------------------------------

	initial begin
		clear_scan();
		sc_limit  = OBJ_MAX;
		idle_odds = 8;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes ignored while skipping, trailer, halt, restart.
		push_req(OP_DATA, 8'h00);
		push_req(OP_DATA, 8'hff);
		push_req(OP_DATA, CHAR_T);
		push_req(OP_DATA, 8'h31);
		push_req(OP_RESTART, 8'hff);
		// bad byte where the count should end
		push_req(OP_DATA, 8'h39);
		push_req(OP_DATA, CHAR_SP);
		push_req(OP_DATA, 8'h61);
		push_req(OP_RESTART, 8'h00);
		// empty subsection, then a header whose first entry starts wrongly
		push_req(OP_DATA, 8'h31);
		push_req(OP_DATA, CHAR_SP);
		push_req(OP_DATA, CHAR_ZERO);
		push_req(OP_DATA, 8'h0a);
		push_req(OP_DATA, CHAR_ZERO);
		push_req(OP_DATA, CHAR_SP);
		push_req(OP_DATA, 8'h31);
		push_req(OP_DATA, CHAR_TAB);
		push_req(OP_DATA, 8'h35);

		// Random phases, each after the first behind a full drain and a fresh object_limit.
		random_phase(100);
		idle_odds = 3;
		write_limit('0);
		random_phase(80);
		idle_odds = 30;
		write_limit(OBJ_W'($urandom_range(1, 40)));
		random_phase(100);
		idle_odds = 8;
		write_limit(OBJ_MAX);
		random_phase(100);
		write_limit(OBJ_W'($urandom_range(0, OBJ_MAX)));
		random_phase(80);
		write_limit(OBJ_W'($urandom_range(8, 60)));
		quiet = 1'b1;
		random_phase(80);
		settle();

		$display("Sent %0d byte requests, checked %0d reports over %0d object_limit writes:",
			bytes_taken, reports_seen, limit_writes);
		$display("  %0d entries, %0d trailers, %0d bad starts, %0d range errors, %0d failures.",
			kind_seen[KIND_ENTRY], kind_seen[KIND_TRAILER], kind_seen[KIND_BAD_START],
			kind_seen[KIND_RANGE], fail_count);
		if (fail_count == 0 && reports_due.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

// ----- xref_subsection_parser.f -----
src/xsp_pkg.sv
src/xsp_in_stage.sv
src/xsp_core.sv
src/xsp_out_stage.sv
src/xref_subsection_parser.sv
tb/tb.sv
